[hdl/tdpj_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdpj_pkg;

    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int DOT_W   = 44;
    localparam int NORM_W  = 46;
    localparam int NSUM_W  = NORM_W + 1;
    localparam int LEN_W   = 13;
    localparam int CODE_W  = 8;
    localparam int FRAC_W  = 16;

    localparam logic [LEN_W-1:0] MAX_VECTOR_LENGTH = 13'd4096;
    localparam logic [LEN_W-1:0] RESET_LENGTH      = 13'd2048;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [NSUM_W-1:0] norm_sum;
    } job_t;

    typedef struct packed {
        logic              kept;
        logic [DOT_W-1:0]  dot;
        logic [CODE_W-1:0] code;
    } result_t;

endpackage

`default_nettype wire

[hdl/tdpj_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdpj_front
    import tdpj_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic signed [ELEM_W-1:0] elem_a,
    input  wire logic signed [ELEM_W-1:0] elem_b,
    input  wire logic [NORM_W-1:0]        norm_a,
    input  wire logic [NORM_W-1:0]        norm_b,
    input  wire logic                     last_element,
    output logic                          job_push,
    output job_t                          job
);

    logic [DOT_W-1:0]         acc_reg;
    logic [DOT_W-1:0]         acc_next;
    logic signed [PROD_W-1:0] prod;
    logic [DOT_W-1:0]         sum_with_prod;

    assign prod          = elem_a * elem_b;
    assign sum_with_prod = acc_reg + {{(DOT_W-PROD_W){prod[PROD_W-1]}}, prod};

    // Emit a job on the final pair and clear the running sum
    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = last_element ? '0 : sum_with_prod;
        end
    end

    assign job_push     = accept && last_element;
    assign job.dot      = sum_with_prod;
    assign job.norm_sum = {1'b0, norm_a} + {1'b0, norm_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tdpj_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdpj_queue
    import tdpj_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  job_t      wr_job,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_job,
    output logic      empty
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

[hdl/tdpj_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdpj_back
    import tdpj_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LEN_W-1:0] vector_length,
    input  wire logic             job_empty,
    input  job_t                  job,
    output logic                  job_pop,
    input  wire logic             res_pop,
    output logic                  res_valid,
    output result_t               res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULT = 3'd1;
    localparam logic [2:0] ST_SUMR = 3'd2;
    localparam logic [2:0] ST_TEST = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    localparam int LO_W  = 24;
    localparam int HI_W  = NSUM_W - LO_W;
    localparam int PLO_W = LEN_W + LO_W;
    localparam int PHI_W = LEN_W + HI_W;
    localparam int R_W   = 59;
    localparam int N_W   = DOT_W - 1 + FRAC_W;
    localparam int DIV_W = 68;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic              res_valid_reg;
    logic              res_valid_next;

    logic [DOT_W-1:0]  dot_reg;
    logic [DOT_W-1:0]  dot_next;
    logic [NSUM_W-1:0] nsum_reg;
    logic [NSUM_W-1:0] nsum_next;
    logic [PLO_W-1:0]  plo_reg;
    logic [PLO_W-1:0]  plo_next;
    logic [PHI_W-1:0]  phi_reg;
    logic [PHI_W-1:0]  phi_next;
    logic [R_W-1:0]    r_reg;
    logic [R_W-1:0]    r_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  ysh_reg;
    logic [DIV_W-1:0]  ysh_next;
    logic [CODE_W-1:0] q_reg;
    logic [CODE_W-1:0] q_next;
    logic [2:0]        cnt_reg;
    logic [2:0]        cnt_next;
    logic              kept_reg;
    logic              kept_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    result_t           res_reg;
    result_t           res_next;

    logic [LEN_W-1:0]  len_eff;
    logic [N_W-1:0]    n;
    logic              positive;
    logic [63:0]       n20;
    logic              over_thresh;
    logic              saturate;
    logic [R_W-1:0]    d;
    logic [DIV_W-1:0]  dividend;
    logic              ge;

    // Zero length counts as one, long lengths saturate
    always_comb
    begin
        if (vector_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (vector_length > MAX_VECTOR_LENGTH)
        begin
            len_eff = MAX_VECTOR_LENGTH;
        end
        else
        begin
            len_eff = vector_length;
        end
    end

    assign n           = {dot_reg[DOT_W-2:0], {FRAC_W{1'b0}}};
    assign positive    = (dot_reg != '0) && !dot_reg[DOT_W-1];
    assign n20         = {1'b0, n, 4'b0} + {3'b0, n, 2'b0};
    assign over_thresh = positive && (n20 > {{(64-R_W){1'b0}}, r_reg});
    assign saturate    = ({n, 1'b0} >= {1'b0, r_reg});
    assign d           = r_reg - n;
    // 510*n + d, the numerator of the rounded quotient
    assign dividend    = {n, 9'b0} - {8'b0, n, 1'b0} + {{(DIV_W-R_W){1'b0}}, d};
    assign ge          = (rem_reg >= ysh_reg);

    assign job_pop   = (state_reg == ST_IDLE) && !job_empty;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        dot_next       = dot_reg;
        nsum_next      = nsum_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        ysh_next       = ysh_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        kept_next      = kept_reg;
        code_next      = code_reg;
        res_next       = res_reg;

        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    dot_next   = job.dot;
                    nsum_next  = job.norm_sum;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                plo_next   = len_eff * nsum_reg[LO_W-1:0];
                phi_next   = len_eff * nsum_reg[NSUM_W-1:LO_W];
                state_next = ST_SUMR;
            end
            ST_SUMR:
            begin
                r_next     = R_W'({phi_reg, {LO_W{1'b0}}} + {{(PHI_W + LO_W - PLO_W){1'b0}}, plo_reg});
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                kept_next = over_thresh;
                if (!over_thresh)
                begin
                    code_next  = '0;
                    state_next = ST_HOLD;
                end
                else if (saturate)
                begin
                    code_next  = '1;
                    state_next = ST_HOLD;
                end
                else
                begin
                    rem_next   = dividend;
                    ysh_next   = {{(DIV_W-R_W-8){1'b0}}, d, 8'b0};
                    q_next     = '0;
                    cnt_next   = 3'd7;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, most significant first
                if (ge)
                begin
                    rem_next = rem_reg - ysh_reg;
                end
                ysh_next = ysh_reg >> 1;
                q_next   = {q_reg[CODE_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    code_next  = {q_reg[CODE_W-2:0], ge};
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!res_valid_reg)
                begin
                    res_next.kept  = kept_reg;
                    res_next.dot   = dot_reg;
                    res_next.code  = code_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg  <= dot_next;
        nsum_reg <= nsum_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        r_reg    <= r_next;
        rem_reg  <= rem_next;
        ysh_reg  <= ysh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        kept_reg <= kept_next;
        code_reg <= code_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

[hdl/thresholded_dot_product_jaccard_top.sv]
// Thresholded dot product with Jaccard estimate. Element pairs of two signed
// 16-bit vectors are pushed one beat per cycle while the job queue has room;
// the front end multiplies and accumulates each pair into a 44-bit running
// sum that wraps on overflow. The beat with last_element high closes the
// vector pair: its product joins the sum, the sum and norm_a + norm_b are
// handed to a two-entry job queue, and the accumulator clears, so the next
// vector pair can stream in at once. The back end takes one job at a time:
// the 13 x 47-bit length-times-norm product is formed in two halves and
// summed, then the threshold test (20*dot*2^16 > L*(norm_a+norm_b)) runs,
// and, for kept pairs that do not saturate, a restoring divider yields
// round(255*N/(L*S-N)), rounded half away from zero. The back end limits
// the sustained rate of vector pairs, while element beats keep flowing at
// one per cycle until the job queue is full. Results are held in an output
// register until popped; the back end works on the next job meanwhile but
// waits in its hold state while that register is still occupied. The user
// must write vector_length through cfg_wr_en / cfg_wr_data only while the
// block is idle, which the block itself does not enforce; it resets to
// 2048, zero acts as 1 and values above 4096 act as 4096.
`timescale 1ns / 1ps
`default_nettype none

module thresholded_dot_product_jaccard_top
    import tdpj_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [ELEM_W-1:0] elem_a,
    input  wire logic signed [ELEM_W-1:0] elem_b,
    input  wire logic [NORM_W-1:0]        norm_a,
    input  wire logic [NORM_W-1:0]        norm_b,
    input  wire logic                     last_element,
    output logic                          empty,
    input  wire logic                     pop,
    output logic                          pair_kept,
    output logic signed [DOT_W-1:0]       dot_value,
    output logic [CODE_W-1:0]             similarity_code,
    input  wire logic                     cfg_wr_en,
    input  wire logic [LEN_W-1:0]         cfg_wr_data
);

    logic [LEN_W-1:0] vector_length_reg;
    logic [LEN_W-1:0] vector_length_next;
    logic             accept;
    logic             job_push;
    job_t             job_in;
    job_t             job_out;
    logic             job_empty;
    logic             job_pop;
    logic             res_valid;
    result_t          res;

    // Take a beat only when the job queue has room
    assign accept = push && !full;

    assign vector_length_next = cfg_wr_en ? cfg_wr_data : vector_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= RESET_LENGTH;
        end
        else
        begin
            vector_length_reg <= vector_length_next;
        end
    end

    // Front: multiply-accumulate, one job per vector pair
    tdpj_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .elem_a       (elem_a),
        .elem_b       (elem_b),
        .norm_a       (norm_a),
        .norm_b       (norm_b),
        .last_element (last_element),
        .job_push     (job_push),
        .job          (job_in)
    );

    // Decouple the streaming front from the multi-cycle back
    tdpj_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .full   (full),
        .rd_en  (job_pop),
        .rd_job (job_out),
        .empty  (job_empty)
    );

    // Back: threshold test, divider and output register
    tdpj_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .vector_length (vector_length_reg),
        .job_empty     (job_empty),
        .job           (job_out),
        .job_pop       (job_pop),
        .res_pop       (pop),
        .res_valid     (res_valid),
        .res           (res)
    );

    assign empty           = !res_valid;
    assign pair_kept       = res.kept;
    assign dot_value       = res.dot;
    assign similarity_code = res.code;

endmodule

`default_nettype wire

[tb/tb_thresholded_dot_product_jaccard_top.sv]
`timescale 1ns / 1ps

module tb_thresholded_dot_product_jaccard_top;
    import tdpj_pkg::*;

    localparam int CLK_HALF_NS     = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int TIMEOUT_CYCLES  = 1_000_000;
    localparam int DRAIN_TAIL      = 32;    // idle margin after the last score is popped
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int HOLD_VECTORS    = 40;
    localparam int PHASES          = 8;
    localparam int RANDOM_BEATS    = 1100;
    localparam int THRESH_RATIO    = 20;
    localparam int CODE_SAT        = 255;

    localparam logic [NORM_W-1:0] NORM_FULL    = '1;
    localparam logic [63:0]       NORM_SUM_MAX = 64'(NORM_FULL) * 2;

    typedef struct packed {
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
        logic              last;
    } beat_t;

    // One directed beat; 'typed' says the expected result below is used as is
    typedef struct packed {
        beat_t   beat;
        logic    typed;
        result_t want;
    } row_t;

    typedef enum int {ELEM_FULL, ELEM_TRACK, ELEM_EXTREME, ELEM_SMALL, ELEM_OPPOSED} elem_mix_e;
    typedef enum int {RX_EAGER, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mix_e;

    // Directed beats, run at the reset length of 2048
    localparam row_t DIRECTED_ROWS [16] = '{
        // zero vectors: nothing to keep
        '{'{16'h0000, 16'h0000, 46'd0, 46'd0, 1'b1}, 1'b1, '{1'b0, 44'd0, 8'd0}},
        // positive dot with zero norms: denominator vanishes, code saturates
        '{'{16'h7FFF, 16'h7FFF, 46'd0, 46'd0, 1'b1}, 1'b1, '{1'b1, 44'd1073676289, 8'd255}},
        // largest product against full-scale norms
        '{'{16'h8000, 16'h8000, NORM_FULL, NORM_FULL, 1'b1}, 1'b1, '{1'b0, 44'd1073741824, 8'd0}},
        // most negative product
        '{'{16'h8000, 16'h7FFF, NORM_FULL, 46'd0, 1'b1}, 1'b1,
          '{1'b0, -44'sd1073709056, 8'd0}},
        // dot of one exactly on the threshold (20*N == L*S): rejected
        '{'{16'h0001, 16'h0001, 46'd640, 46'd0, 1'b1}, 1'b1, '{1'b0, 44'd1, 8'd0}},
        // one below the threshold norm: kept
        '{'{16'h0001, 16'h0001, 46'd639, 46'd0, 1'b1}, 1'b0, '0},
        // ratio of exactly one
        '{'{16'h0001, 16'h0001, 46'd0, 46'd64, 1'b1}, 1'b1, '{1'b1, 44'd1, 8'd255}},
        // 25.5 rounds away from zero
        '{'{16'hFFFF, 16'hFFFF, 46'd200, 46'd152, 1'b1}, 1'b1, '{1'b1, 44'd1, 8'd26}},
        // 42.5 rounds away from zero
        '{'{16'h0001, 16'h0001, 46'd112, 46'd112, 1'b1}, 1'b1, '{1'b1, 44'd1, 8'd43}},
        // four-beat pair; norms on the early beats must be ignored
        '{'{16'h8000, 16'h8000, NORM_FULL, NORM_FULL, 1'b0}, 1'b0, '0},
        '{'{16'h8000, 16'h8000, 46'd0, 46'd0, 1'b0}, 1'b0, '0},
        '{'{16'h7FFF, 16'h8000, 46'h2AAA_AAAA_AAAA, 46'd0, 1'b0}, 1'b0, '0},
        '{'{16'hFFFF, 16'h0001, 46'h1555_5555_5555, 46'h0000_0FFF_FFFF, 1'b1}, 1'b0, '0},
        // tiny norm sum: N far above L*S
        '{'{16'hFFFF, 16'hFFFF, 46'd1, 46'd0, 1'b1}, 1'b1, '{1'b1, 44'd1, 8'd255}},
        // two-beat negative dot
        '{'{16'h0005, 16'hFFF9, NORM_FULL, NORM_FULL, 1'b0}, 1'b0, '0},
        '{'{16'hFFFD, 16'h0002, 46'd0, 46'd0, 1'b1}, 1'b1, '{1'b0, -44'sd41, 8'd0}}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic signed [ELEM_W-1:0] elem_a = '0;
    logic signed [ELEM_W-1:0] elem_b = '0;
    logic [NORM_W-1:0]        norm_a = '0;
    logic [NORM_W-1:0]        norm_b = '0;
    logic                     last_element = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic                     pair_kept;
    logic signed [DOT_W-1:0]  dot_value;
    logic [CODE_W-1:0]        similarity_code;
    logic                     cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]         cfg_wr_data = '0;

    // Predictor state: our own copy of the accumulator and the length register
    logic [DOT_W-1:0] dot_tally = '0;
    logic [LEN_W-1:0] length_reg = RESET_LENGTH;
    result_t          awaited_scores [$];
    result_t          head_score;

    int  error_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;
    int  hold_req = 0;
    int  hold_served = 0;

    thresholded_dot_product_jaccard_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .elem_a          (elem_a),
        .elem_b          (elem_b),
        .norm_a          (norm_a),
        .norm_b          (norm_b),
        .last_element    (last_element),
        .empty           (empty),
        .pop             (pop),
        .pair_kept       (pair_kept),
        .dot_value       (dot_value),
        .similarity_code (similarity_code),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    always #CLK_HALF_NS clk = ~clk;

    // Zero acts as one, anything past the maximum saturates
    function automatic logic [63:0] effective_len(input logic [LEN_W-1:0] len);
        if (len == '0)
        begin
            return 64'd1;
        end
        if (len > MAX_VECTOR_LENGTH)
        begin
            return 64'(MAX_VECTOR_LENGTH);
        end
        return 64'(len);
    endfunction

    // Threshold test and quantized Jaccard estimate for one finished vector pair
    function automatic result_t score_vector_pair(input logic [DOT_W-1:0] dot,
                                                  input logic [NORM_W-1:0] na,
                                                  input logic [NORM_W-1:0] nb,
                                                  input logic [LEN_W-1:0] len);
        logic [63:0]  n;
        logic [63:0]  r;
        logic [63:0]  d;
        logic [127:0] num;
        logic [127:0] q;
        result_t      res;
        res.kept = 1'b0;
        res.dot  = dot;
        res.code = '0;
        if (dot != '0 && !dot[DOT_W-1])
        begin
            n = {4'd0, dot, 16'd0};
            r = effective_len(len) * (64'(na) + 64'(nb));
            if (n > r / THRESH_RATIO)
            begin
                res.kept = 1'b1;
                if (n >= r || n >= r - n)
                begin
                    res.code = CODE_SAT[CODE_W-1:0];
                end
                else
                begin
                    // round half away from zero: floor((2*255*n + d) / (2*d))
                    d   = r - n;
                    num = {64'd0, n} * 128'(2 * CODE_SAT) + {64'd0, d};
                    q   = num / {63'd0, d, 1'b0};
                    res.code = (q > CODE_SAT) ? CODE_SAT[CODE_W-1:0] : q[CODE_W-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic logic [NORM_W-1:0] rand_norm();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[NORM_W-1:0];
    endfunction

    function automatic int draw_elem(input elem_mix_e mix);
        case (mix)
            ELEM_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       return -32768;
                    1:       return -1;
                    2:       return 0;
                    3:       return 1;
                    default: return 32767;
                endcase
            end
            ELEM_SMALL: return int'($urandom_range(0, 16)) - 8;
            default:    return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Offer one beat, hold it until accepted, then advance the predictor
    task automatic send_beat(input beat_t bt, input logic typed, input result_t typed_want);
        logic signed [PROD_W-1:0] prod;
        result_t                  want;
        if (burst_left == 0)
        begin
            if (sender_gaps)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push         <= 1'b1;
        elem_a       <= bt.a;
        elem_b       <= bt.b;
        norm_a       <= bt.na;
        norm_b       <= bt.nb;
        last_element <= bt.last;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        prod      = $signed(bt.a) * $signed(bt.b);
        dot_tally = dot_tally + {{(DOT_W - PROD_W){prod[PROD_W-1]}}, prod};
        if (bt.last)
        begin
            want = score_vector_pair(dot_tally, bt.na, bt.nb, length_reg);
            awaited_scores.insert(awaited_scores.size(), typed ? typed_want : want);
            dot_tally = '0;
        end
    endtask

    // One random vector pair; most are shaped so the threshold and code logic get exercised
    task automatic send_vector_pair(input int nbeats);
        elem_mix_e   mix;
        int          k;
        int          ai;
        int          bi;
        int          roll;
        longint      dot_sum;
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] split;
        beat_t       bt;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            mix = ELEM_FULL;
        else if (roll < 7)
            mix = ELEM_TRACK;
        else if (roll == 7)
            mix = ELEM_EXTREME;
        else if (roll == 8)
            mix = ELEM_SMALL;
        else
            mix = ELEM_OPPOSED;
        dot_sum = 0;
        for (k = 0; k < nbeats; k++)
        begin
            ai = draw_elem(mix);
            case (mix)
                ELEM_TRACK:   bi = ai + int'($urandom_range(0, 64)) - 32;
                ELEM_OPPOSED: bi = -ai;
                default:      bi = draw_elem(mix);
            endcase
            if (bi > 32767)
                bi = 32767;
            if (bi < -32768)
                bi = -32768;
            dot_sum += longint'(ai) * longint'(bi);
            bt.a    = ai[ELEM_W-1:0];
            bt.b    = bi[ELEM_W-1:0];
            bt.last = (k == nbeats - 1);
            roll    = $urandom_range(0, 9);
            if (!bt.last || dot_sum <= 0 || roll < 2)
            begin
                bt.na = rand_norm();
                bt.nb = rand_norm();
            end
            else if (roll == 2)
            begin
                // near-zero norms: saturating code
                bt.na = NORM_W'($urandom_range(0, 3));
                bt.nb = NORM_W'($urandom_range(0, 3));
            end
            else
            begin
                // aim L*S at 0.5x .. 30x of N so the pair lands around the threshold
                n = 64'(dot_sum) << FRAC_W;
                s = n * $urandom_range(4, 240) / 8 / effective_len(length_reg)
                    + $urandom_range(0, 3);
                if (s > NORM_SUM_MAX)
                    s = NORM_SUM_MAX;
                if (s > 64'(NORM_FULL))
                begin
                    bt.na = NORM_FULL;
                    split = s - 64'(NORM_FULL);
                end
                else
                begin
                    split = {$urandom, $urandom} % (s + 1);
                    bt.na = split[NORM_W-1:0];
                    split = s - split;
                end
                bt.nb = split[NORM_W-1:0];
            end
            send_beat(bt, 1'b0, '0);
        end
    endtask

    // Drop push and wait until every awaited score has been popped, plus a tail
    task automatic wait_for_drain();
        push <= 1'b0;
        while (awaited_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Result monitor: compare every popped beat with the oldest awaited score
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (awaited_scores.size() == 0)
            begin
                $display("%0t: result with none awaited: kept=%0b dot=%0d code=%0d",
                         $time, pair_kept, dot_value, similarity_code);
                error_count++;
            end
            else
            begin
                head_score = awaited_scores.pop_front();
                if (pair_kept !== head_score.kept || dot_value !== head_score.dot ||
                    similarity_code !== head_score.code)
                begin
                    $display("%0t: mismatch: expected kept=%0b dot=%0d code=%0d",
                             $time, head_score.kept, $signed(head_score.dot),
                             head_score.code);
                    $display("%0t:           actual   kept=%0b dot=%0d code=%0d",
                             $time, pair_kept, dot_value, similarity_code);
                    error_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("%0t: timeout, %0d scores still awaited", $time, awaited_scores.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: pop on a shifting pattern, with a long hold-off when requested
    initial
    begin : rx_pattern
        rx_mix_e mode;
        int      left;
        int      held;
        mode = RX_EAGER;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_req)
            begin
                pop <= 1'b0;
                for (held = 0; held < RX_HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                hold_served++;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mix_e'($urandom_range(0, 3));
                    left = $urandom_range(16, 128);
                end
                left--;
                case (mode)
                    RX_EAGER:  pop <= 1'b1;
                    RX_COIN:   pop <= 1'($urandom_range(0, 1));
                    RX_SPARSE: pop <= ($urandom_range(0, 5) == 0);
                    default:   pop <= ~pop;
                endcase
            end
        end
    end

    // Stimulus: directed table at the reset length, then random phases per length
    initial
    begin : stimulus
        int               i;
        int               phase;
        int               phase_beats;
        int               nbeats;
        logic [LEN_W-1:0] len_next;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       len_next = '0;                      // acts as one
                1:       len_next = 13'd1;
                2:       len_next = MAX_VECTOR_LENGTH;
                3:       len_next = '1;                      // saturates
                4:       len_next = MAX_VECTOR_LENGTH + 13'd1;
                5:       len_next = 13'd3;
                6:       len_next = RESET_LENGTH;
                default: len_next = LEN_W'($urandom_range(2, 8191));
            endcase

            // Write the length only with the block fully drained
            wait_for_drain();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= len_next;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            length_reg   = len_next;

            sender_gaps = (phase != 4);
            phase_beats = 0;

            if (phase == 1)
            begin
                // Stall the receiver and push short pairs, enough for the input to back up
                hold_req++;
                for (i = 0; i < HOLD_VECTORS; i++)
                begin
                    send_vector_pair(1);
                end
                phase_beats += HOLD_VECTORS;
            end

            while (phase_beats < RANDOM_BEATS / PHASES)
            begin
                nbeats = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                send_vector_pair(nbeats);
                phase_beats += nbeats;
            end
        end

        wait_for_drain();
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/tdpj_pkg.sv
hdl/tdpj_front.sv
hdl/tdpj_queue.sv
hdl/tdpj_back.sv
hdl/thresholded_dot_product_jaccard_top.sv
tb/tb_thresholded_dot_product_jaccard_top.sv
